[design/olist_pkg.sv]
package olist_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int OP_W       = 4;
  localparam int ST_W       = 3;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT     = 4'd0,
    OP_INS_BACK      = 4'd1,
    OP_INS_AFTER_KEY = 4'd2,
    OP_INS_AFTER_POS = 4'd3,
    OP_DEL_FRONT     = 4'd4,
    OP_DEL_BACK      = 4'd5,
    OP_DEL_KEY       = 4'd6,
    OP_DEL_POS       = 4'd7,
    OP_FIND_FIRST    = 4'd8,
    OP_FIND_LAST     = 4'd9,
    OP_READ          = 4'd10,
    OP_CLEAR         = 4'd11
  } opcode_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_RANGE     = 3'd4
  } status_t;

  // Shift command broadcast to every cell of the chain
  typedef struct packed {
    logic                  ins;
    logic                  del;
    logic [IDX_W-1:0]      at;
    logic [DATA_WIDTH-1:0] data;
  } cell_ctrl_t;

  // Lowest set bit index (zero when none)
  function automatic logic [IDX_W-1:0] first_set(input logic [DEPTH-1:0] v);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (v[i]) r = IDX_W'(i);
    end
    return r;
  endfunction

  // Highest set bit index (zero when none)
  function automatic logic [IDX_W-1:0] last_set(input logic [DEPTH-1:0] v);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (v[i]) r = IDX_W'(i);
    end
    return r;
  endfunction

endpackage

[design/olist_cell.sv]
module olist_cell (
  input  logic                            clk,
  input  olist_pkg::cell_ctrl_t           ctrl,
  input  logic [olist_pkg::IDX_W-1:0]     cell_index,
  input  logic [olist_pkg::DATA_WIDTH-1:0] left_entry,
  input  logic [olist_pkg::DATA_WIDTH-1:0] right_entry,
  input  logic [olist_pkg::DATA_WIDTH-1:0] probe_value,
  input  logic [olist_pkg::DATA_WIDTH-1:0] probe_key,
  output logic [olist_pkg::DATA_WIDTH-1:0] entry,
  output logic                            match_value,
  output logic                            match_key
);
  import olist_pkg::*;

  // Compare the held word against both broadcast probes
  assign match_value = (entry == probe_value);
  assign match_key   = (entry == probe_key);

  // Load the new word, take the left neighbor on insert, the right one on delete
  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (cell_index == ctrl.at) begin
        entry <= ctrl.data;
      end else if (cell_index > ctrl.at) begin
        entry <= left_entry;
      end
    end else if (ctrl.del) begin
      if (cell_index >= ctrl.at) begin
        entry <= right_entry;
      end
    end
  end

endmodule

[design/ordered_list_engine.sv]
// A reply word is registered when the pending item word executes, and waits there
// while the reply side stalls, holding the next item word pending.
// No new item word is taken until the pending one executes; the cell chain compares
// on accept, shifts on execute, and the list state must settle before the next compare.
// Reset: rst (synchronous, active high) empties the list and drops any pending or
// reply word; cell contents are not cleared.
module ordered_list_engine (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_stall,
  input  logic [olist_pkg::OP_W-1:0]       opcode,
  input  logic [olist_pkg::DATA_WIDTH-1:0] value,
  input  logic [olist_pkg::DATA_WIDTH-1:0] key,
  input  logic [olist_pkg::IDX_W-1:0]      position,
  output logic                             reply_valid,
  input  logic                             reply_stall,
  output logic [olist_pkg::ST_W-1:0]       status,
  output logic                             found,
  output logic [olist_pkg::IDX_W-1:0]      found_position,
  output logic [olist_pkg::DATA_WIDTH-1:0] read_value,
  output logic [olist_pkg::CNT_W-1:0]      count
);
  import olist_pkg::*;

  logic [DATA_WIDTH-1:0] cell_entry [DEPTH];
  logic [DEPTH-1:0]      cell_match_value;
  logic [DEPTH-1:0]      cell_match_key;
  logic [DEPTH-1:0]      live;
  cell_ctrl_t            ctrl;

  logic [CNT_W-1:0]      entry_count;
  logic [CNT_W-1:0]      entry_count_next;

  // Pending stage
  logic                  pend;
  logic [OP_W-1:0]       pend_op;
  logic [DATA_WIDTH-1:0] pend_value;
  logic [IDX_W-1:0]      pend_position;
  logic [DEPTH-1:0]      pend_match_value;
  logic [DEPTH-1:0]      pend_match_key;
  logic [DATA_WIDTH-1:0] pend_read;

  logic                  accept;
  logic                  exec;

  logic [ST_W-1:0]       status_next;
  logic                  found_next;
  logic [IDX_W-1:0]      found_position_next;
  logic [DATA_WIDTH-1:0] read_value_next;

  logic                  full;
  logic                  empty;
  logic                  pos_bad;
  logic [DEPTH-1:0]      hit_value;
  logic [DEPTH-1:0]      hit_key;
  logic [IDX_W-1:0]      first_value;
  logic [IDX_W-1:0]      last_value;
  logic [IDX_W-1:0]      first_key;

  // Build the chain; the end cells see themselves as the missing neighbor
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_word;
    logic [DATA_WIDTH-1:0] right_word;

    if (i == 0) begin : g_first
      assign left_word = cell_entry[i];
    end else begin : g_mid_l
      assign left_word = cell_entry[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_word = cell_entry[i];
    end else begin : g_mid_r
      assign right_word = cell_entry[i+1];
    end

    olist_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .cell_index  (IDX_W'(i)),
      .left_entry  (left_word),
      .right_entry (right_word),
      .probe_value (value),
      .probe_key   (key),
      .entry       (cell_entry[i]),
      .match_value (cell_match_value[i]),
      .match_key   (cell_match_key[i])
    );

    assign live[i] = (CNT_W'(i) < entry_count);
  end

  // Take one item at a time
  assign item_stall = pend;
  assign accept     = item_valid && !pend;
  assign exec       = pend && (!reply_valid || !reply_stall);

  // Capture match vectors and the read word on accept
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (accept) begin
      pend <= 1'b1;
    end else if (exec) begin
      pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_op          <= opcode;
      pend_value       <= value;
      pend_position    <= position;
      pend_match_value <= cell_match_value;
      pend_match_key   <= cell_match_key;
      pend_read        <= cell_entry[position];
    end
  end

  // Resolve searches against the live part of the list
  assign hit_value   = pend_match_value & live;
  assign hit_key     = pend_match_key & live;
  assign first_value = first_set(hit_value);
  assign last_value  = last_set(hit_value);
  assign first_key   = first_set(hit_key);
  assign full        = (entry_count == CNT_W'(DEPTH));
  assign empty       = (entry_count == '0);
  assign pos_bad     = (CNT_W'(pend_position) >= entry_count);

  // Decode the pending operation into a shift command and a reply
  always_comb begin
    ctrl                = '0;
    ctrl.data           = pend_value;
    entry_count_next    = entry_count;
    status_next         = ST_OK;
    found_next          = 1'b0;
    found_position_next = '0;
    read_value_next     = '0;

    unique case (opcode_t'(pend_op))
      OP_INS_FRONT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          ctrl.ins = 1'b1;
          ctrl.at  = '0;
        end
      end
      OP_INS_BACK: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          ctrl.ins = 1'b1;
          ctrl.at  = IDX_W'(entry_count);
        end
      end
      OP_INS_AFTER_KEY: begin
        if (full) begin
          status_next = ST_FULL;
        end else if (hit_key == '0) begin
          status_next = ST_NOT_FOUND;
        end else begin
          ctrl.ins = 1'b1;
          ctrl.at  = first_key + 1'b1;
        end
      end
      OP_INS_AFTER_POS: begin
        if (full) begin
          status_next = ST_FULL;
        end else if (pos_bad) begin
          status_next = ST_RANGE;
        end else begin
          ctrl.ins = 1'b1;
          ctrl.at  = pend_position + 1'b1;
        end
      end
      OP_DEL_FRONT: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          ctrl.del = 1'b1;
          ctrl.at  = '0;
        end
      end
      OP_DEL_BACK: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          ctrl.del = 1'b1;
          ctrl.at  = IDX_W'(entry_count - 1'b1);
        end
      end
      OP_DEL_KEY: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else if (hit_value == '0) begin
          status_next = ST_NOT_FOUND;
        end else begin
          ctrl.del = 1'b1;
          ctrl.at  = first_value;
        end
      end
      OP_DEL_POS: begin
        if (pos_bad) begin
          status_next = ST_RANGE;
        end else begin
          ctrl.del = 1'b1;
          ctrl.at  = pend_position;
        end
      end
      OP_FIND_FIRST: begin
        if (hit_value == '0) begin
          status_next = ST_NOT_FOUND;
        end else begin
          found_next          = 1'b1;
          found_position_next = first_value;
        end
      end
      OP_FIND_LAST: begin
        if (hit_value == '0) begin
          status_next = ST_NOT_FOUND;
        end else begin
          found_next          = 1'b1;
          found_position_next = last_value;
        end
      end
      OP_READ: begin
        if (pos_bad) begin
          status_next = ST_RANGE;
        end else begin
          read_value_next = pend_read;
        end
      end
      OP_CLEAR: begin
        entry_count_next = '0;
      end
      default: begin
      end
    endcase

    if (ctrl.ins) begin
      entry_count_next = entry_count + 1'b1;
    end else if (ctrl.del) begin
      entry_count_next = entry_count - 1'b1;
    end

    // Hold the cells unless the operation really runs this cycle
    if (!exec) begin
      ctrl.ins = 1'b0;
      ctrl.del = 1'b0;
    end
  end

  // Advance the fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (exec) begin
      entry_count <= entry_count_next;
    end
  end

  // Reply register
  always_ff @(posedge clk) begin
    if (rst) begin
      reply_valid <= 1'b0;
    end else if (exec) begin
      reply_valid <= 1'b1;
    end else if (!reply_stall) begin
      reply_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      status         <= status_next;
      found          <= found_next;
      found_position <= found_position_next;
      read_value     <= read_value_next;
      count          <= entry_count_next;
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(DEPTH))
    else $error("list count above depth");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !exec |=> $stable(entry_count))
    else $error("list count moved without an operation");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    reply_valid && found |-> status == ST_OK)
    else $error("found flag with failing status");

  a_reply_count: assert property (@(posedge clk) disable iff (rst)
    exec |=> reply_valid && count == entry_count)
    else $error("reply count differs from list count");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    accept |=> pend && !accept)
    else $error("second word taken while one is pending");

endmodule
